// File: src/lps_pkg.sv
// ---------------------------------------------------------------------------
// lps_pkg : shared definitions for the line pixel stepper
// Operation codes, default coordinate width and the control structs passed
// between the top level and the line core.
// ---------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // command from the item register into the line core
  typedef struct packed {
    logic fire;
    op_t  op;
  } cmd_t;

  // status from the line core
  typedef struct packed {
    logic produce;  // the presented item yields a pixel
    logic active;   // pixels remain on the current line
  } stat_t;

endpackage

`default_nettype wire

// File: src/lps_core.sv
// ---------------------------------------------------------------------------
// lps_core : line state and combinational step logic
// Holds the current pixel, target, spans and the running cross-product error,
// and works out the next pixel for a start or step command in one pass.
// ---------------------------------------------------------------------------
`default_nettype none

module lps_core #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lps_pkg::cmd_t                cmd,
  input  wire logic signed [COORD_BITS-1:0] x_start,
  input  wire logic signed [COORD_BITS-1:0] y_start,
  input  wire logic signed [COORD_BITS-1:0] x_end,
  input  wire logic signed [COORD_BITS-1:0] y_end,
  output logic signed [COORD_BITS-1:0]      pixel_x,
  output logic signed [COORD_BITS-1:0]      pixel_y,
  output logic                              last,
  output lps_pkg::stat_t                    stat
);

  localparam int SW = COORD_BITS + 1;  // span width
  localparam int EW = COORD_BITS + 2;  // error register width
  localparam int TW = COORD_BITS + 3;  // error candidate width

  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic signed [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt;
  logic signed [SW-1:0]         span_x_r, span_y_r, span_x_nxt, span_y_nxt;
  logic signed [EW-1:0]         err_r, err_nxt;
  logic                         active_r;

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic signed [SW-1:0]         sx_new, sy_new;
  logic signed [TW-1:0]         sx_ext, sy_ext, err_ext, a_term, b_term, ex_v, ey_v;
  logic [TW-1:0]                ex_mag, ey_mag;
  logic                         sx_neg, sx_zero, sy_neg, sy_zero, take_x;
  logic [COORD_BITS-1:0]        dx, dy;

  // order endpoints of axis-aligned lines from smaller to larger
  always_comb begin
    x1 = x_start;
    y1 = y_start;
    x2 = x_end;
    y2 = y_end;
    if (x_start == x_end) begin
      if (y_start > y_end) begin
        y1 = y_end;
        y2 = y_start;
      end
    end else if (y_start == y_end) begin
      if (x_start > x_end) begin
        x1 = x_end;
        x2 = x_start;
      end
    end
  end

  assign sx_new = {x2[COORD_BITS-1], x2} - {x1[COORD_BITS-1], x1};
  assign sy_new = {y2[COORD_BITS-1], y2} - {y1[COORD_BITS-1], y1};

  // error E = offset_x*span_y - offset_y*span_x, kept incrementally:
  // an x step adds sgn(sx)*sy, a y step subtracts sgn(sy)*sx
  assign sx_neg  = span_x_r[SW-1];
  assign sy_neg  = span_y_r[SW-1];
  assign sx_zero = (span_x_r == '0);
  assign sy_zero = (span_y_r == '0);
  assign sx_ext  = TW'(span_x_r);
  assign sy_ext  = TW'(span_y_r);
  assign err_ext = TW'(err_r);

  assign a_term = sx_zero ? '0 : (sx_neg ? -sy_ext : sy_ext);
  assign b_term = sy_zero ? '0 : (sy_neg ? -sx_ext : sx_ext);
  assign ex_v   = err_ext + a_term;
  assign ey_v   = err_ext - b_term;
  assign ex_mag = ex_v[TW-1] ? (~ex_v + 1'b1) : ex_v;
  assign ey_mag = ey_v[TW-1] ? (~ey_v + 1'b1) : ey_v;

  // horizontal lines always step x; on a tie step y
  assign take_x = sy_zero || (ex_mag < ey_mag);
  assign dx     = (sx_neg && !sy_zero) ? '1 : COORD_BITS'(1);
  assign dy     = sy_neg ? '1 : COORD_BITS'(1);

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    span_x_nxt = span_x_r;
    span_y_nxt = span_y_r;
    err_nxt    = err_r;
    unique case (cmd.op)
      lps_pkg::OP_START: begin
        cur_x_nxt  = x1;
        cur_y_nxt  = y1;
        tgt_x_nxt  = x2;
        tgt_y_nxt  = y2;
        span_x_nxt = sx_new;
        span_y_nxt = sy_new;
        err_nxt    = '0;
      end
      lps_pkg::OP_STEP: begin
        if (take_x) begin
          cur_x_nxt = cur_x_r + dx;
          err_nxt   = EW'(ex_v);
        end else begin
          cur_y_nxt = cur_y_r + dy;
          err_nxt   = EW'(ey_v);
        end
      end
      default: begin
        err_nxt = err_r;
      end
    endcase
  end

  assign pixel_x      = cur_x_nxt;
  assign pixel_y      = cur_y_nxt;
  assign last         = (cur_x_nxt == tgt_x_nxt) && (cur_y_nxt == tgt_y_nxt);
  assign stat.produce = (cmd.op == lps_pkg::OP_START) || active_r;
  assign stat.active  = active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      span_x_r <= '0;
      span_y_r <= '0;
      err_r    <= '0;
      active_r <= 1'b0;
    end else if (cmd.fire && stat.produce) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      span_x_r <= span_x_nxt;
      span_y_r <= span_y_nxt;
      err_r    <= err_nxt;
      active_r <= !last;
    end
  end

endmodule

`default_nettype wire

// File: src/line_pixel_stepper.sv
// ---------------------------------------------------------------------------
// line_pixel_stepper : 4-connected line rasteriser
// Walks a line between two endpoints and returns one pixel per start and per step on a line in progress.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : command stream. tuser = operation (start or step), tdata holds
//           x_start, y_start, x_end, y_end; the endpoints matter on start only.
//   out_* : pixel stream. tdata holds pixel_x, pixel_y; tlast marks the final
//           endpoint of the line.
//   A start transfer latches the endpoints and yields the first pixel; each
//   step transfer yields the next one. A step with no line in progress is
//   consumed and yields nothing. A start during a line abandons it.
//   An input transfer is held in the command register, then passes through the
//   step logic into the output register, which raises out_tvalid.
//   Throughput is one command per cycle while out_tready is high; the step is
//   a single add, abs and compare on the running cross-product error, so no
//   item waits on another. When the receiver stalls the output register holds
//   its pixel and the command register fills, after which in_tready drops;
//   steps on an idle line still drain.
//   Reset (rst_n low, synchronous) empties both registers and leaves the
//   stepper idle with all line state at zero.
// ---------------------------------------------------------------------------
`default_nettype none

module line_pixel_stepper #(
  parameter  int COORD_BITS  = lps_pkg::COORD_BITS_DEF,
  localparam int IN_DATA_W   = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // x_start, y_start, x_end, y_end
  input  wire logic                  in_tuser,   // operation
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // pixel_x, pixel_y
  output logic                       out_tlast
);

  localparam int CB = COORD_BITS;

  // command register
  logic                 cmd_valid_r, cmd_valid_nxt;
  lps_pkg::op_t         op_r;
  logic signed [CB-1:0] xs_r, ys_r, xe_r, ye_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  lps_pkg::cmd_t        cmd;
  lps_pkg::stat_t       stat;
  logic signed [CB-1:0] pix_x, pix_y;
  logic                 pix_last;
  logic                 in_xfer, out_free, fire;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  // an idle step needs no room in the output register
  assign fire      = cmd_valid_r && (out_free || !stat.produce);
  assign in_tready = !cmd_valid_r || fire;

  assign cmd.fire = fire;
  assign cmd.op   = op_r;

  lps_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .x_start (xs_r),
    .y_start (ys_r),
    .x_end   (xe_r),
    .y_end   (ye_r),
    .pixel_x (pix_x),
    .pixel_y (pix_y),
    .last    (pix_last),
    .stat    (stat)
  );

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (in_xfer) begin
      cmd_valid_nxt = 1'b1;
    end else if (fire) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && stat.produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: command on input transfer, pixel when one is produced; hold otherwise
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= lps_pkg::op_t'(in_tuser);
      xs_r <= in_tdata[CB-1:0];
      ys_r <= in_tdata[2*CB-1:CB];
      xe_r <= in_tdata[3*CB-1:2*CB];
      ye_r <= in_tdata[4*CB-1:3*CB];
    end
    if (fire && stat.produce) begin
      out_data_r <= OUT_DATA_W'({pix_y, pix_x});
      out_last_r <= pix_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // a step on an idle line never stalls
  a_idle_step_drains : assert property (
    @(posedge clk) disable iff (!rst_n)
    (cmd_valid_r && !stat.produce) |-> fire
  ) else $error("idle step held in command register");

  // the final pixel of a line leaves the stepper idle
  a_last_goes_idle : assert property (
    @(posedge clk) disable iff (!rst_n)
    (fire && stat.produce && pix_last) |=> !stat.active
  ) else $error("stepper still active after final pixel");

  // a produced pixel always lands in the output register
  a_pixel_loaded : assert property (
    @(posedge clk) disable iff (!rst_n)
    (fire && stat.produce) |=> out_valid_r
  ) else $error("pixel lost on its way to the output register");

  // a stalled command holds its contents
  a_cmd_hold : assert property (
    @(posedge clk) disable iff (!rst_n)
    (cmd_valid_r && !fire) |=> (cmd_valid_r && $stable(op_r) && $stable(xs_r)
                                && $stable(ye_r))
  ) else $error("stalled command changed");

endmodule

`default_nettype wire

// File: tb/pixel_path_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pixel_path_checker : scoreboard for the line pixel stepper
// Watches the command and pixel streams, walks each line alongside the block
// and compares every pixel transfer with the oldest pixel still owed.
// ---------------------------------------------------------------------------

module pixel_path_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // x_start, y_start, x_end, y_end
  input  logic        in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // pixel_x, pixel_y
  input  logic        out_tlast,
  output int          mismatches,
  output int          pixels_owed
);
  import lps_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } pixel_t;

  pixel_t pending_pixels[$];
  int     errs = 0;

  logic signed [15:0] cur_x, cur_y, tgt_x, tgt_y;
  logic signed [16:0] off_x, off_y, span_x, span_y;
  logic               line_busy;

  initial begin
    mismatches  = 0;
    pixels_owed = 0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    if (errs < 40)
      $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
    errs++;
  endtask

  function automatic longint abs_cross(input longint a, input longint b,
                                       input longint c, input longint d);
    longint r;
    r = a * b - c * d;
    return (r < 0) ? -r : r;
  endfunction

  // advance the line by one command; emits is set when a pixel follows
  task automatic walk_line(input op_t op, input logic [63:0] coords,
                           output bit emits, output pixel_t px);
    logic signed [15:0] x1, y1, x2, y2, t;
    longint sx, sy, ex, ey;
    emits = 1'b0;
    px    = '0;
    if (op == OP_START) begin
      x1 = coords[15:0];
      y1 = coords[31:16];
      x2 = coords[47:32];
      y2 = coords[63:48];
      // axis-aligned lines run from the smaller coordinate up
      if (x1 == x2) begin
        if (y1 > y2) begin
          t = y1; y1 = y2; y2 = t;
        end
      end else if (y1 == y2) begin
        if (x1 > x2) begin
          t = x1; x1 = x2; x2 = t;
        end
      end
      cur_x     = x1;
      cur_y     = y1;
      tgt_x     = x2;
      tgt_y     = y2;
      off_x     = '0;
      off_y     = '0;
      span_x    = x2 - x1;  // signed, sign-extended to 17 bits
      span_y    = y2 - y1;
      line_busy = 1'b1;
      emits     = 1'b1;
    end else if (line_busy) begin
      if (span_y == 0) begin
        cur_x = cur_x + 16'sd1;
        off_x = off_x + 17'sd1;
      end else begin
        sx = (span_x > 0) ? 1 : ((span_x < 0) ? -1 : 0);
        sy = (span_y > 0) ? 1 : ((span_y < 0) ? -1 : 0);
        ex = abs_cross(longint'(off_x) + sx, span_y, off_y, span_x);
        ey = abs_cross(off_x, span_y, longint'(off_y) + sy, span_x);
        // a tie goes to y
        if (ex < ey) begin
          cur_x = cur_x + 16'(sx);
          off_x = off_x + 17'(sx);
        end else begin
          cur_y = cur_y + 16'(sy);
          off_y = off_y + 17'(sy);
        end
      end
      emits = 1'b1;
    end
    if (emits) begin
      px.x    = cur_x;
      px.y    = cur_y;
      px.last = (cur_x == tgt_x) && (cur_y == tgt_y);
      if (px.last)
        line_busy = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    bit     emits;
    pixel_t px, want;
    if (!rst_n) begin
      cur_x     = '0;
      cur_y     = '0;
      tgt_x     = '0;
      tgt_y     = '0;
      off_x     = '0;
      off_y     = '0;
      span_x    = '0;
      span_y    = '0;
      line_busy = 1'b0;
      pending_pixels.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        walk_line(op_t'(in_tuser), in_tdata, emits, px);
        if (emits)
          pending_pixels.push_back(px);
      end
      if (out_tvalid && out_tready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected pixel, pixel_x", 0,
                          $signed(out_tdata[15:0]));
        end else begin
          want = pending_pixels.pop_front();
          if ($signed(out_tdata[15:0]) != want.x)
            report_mismatch("pixel_x", want.x, $signed(out_tdata[15:0]));
          if ($signed(out_tdata[31:16]) != want.y)
            report_mismatch("pixel_y", want.y, $signed(out_tdata[31:16]));
          if (out_tlast !== want.last)
            report_mismatch("last", want.last, out_tlast);
        end
      end
    end
    mismatches  <= errs;
    pixels_owed <= pending_pixels.size();
  end

endmodule

// File: tb/line_pixel_stepper_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// line_pixel_stepper_tb : testbench for the 4-connected line rasteriser
// Drives directed lines at the coordinate extremes, then random short lines
// that are run to the end, cut short or followed by idle steps, under three
// patterns of sender and receiver stalls. A separate checker scores pixels.
// ---------------------------------------------------------------------------

module line_pixel_stepper_tb;

  localparam int CYCLE_LIMIT = 200000;
  // random items; the directed lines add about 25 more
  localparam int ITEM_TARGET = 525;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;  // x_start, y_start, x_end, y_end
  logic        in_tuser   = 1'b0;  // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // pixel_x, pixel_y
  logic        out_tlast;

  int mismatches;
  int pixels_owed;
  int tx_idle_pct = 22;
  int rx_idle_pct = 68;
  int cycle_count = 0;

  line_pixel_stepper uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  pixel_path_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .pixels_owed (pixels_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] pack_coords(input int xs, input int ys,
                                              input int xe, input int ye);
    return {16'(ye), 16'(xe), 16'(ys), 16'(xs)};
  endfunction

  // hold the command until it transfers, then idle cycle by cycle at random
  task automatic send_item(input lps_pkg::op_t op, input logic [63:0] coords);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= coords;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_line(input int xs, input int ys, input int xe, input int ye,
                          input int steps);
    send_item(lps_pkg::OP_START, pack_coords(xs, ys, xe, ye));
    repeat (steps) send_item(lps_pkg::OP_STEP, {$urandom, $urandom});
  endtask

  task automatic drain_pixels();
    // the owed count is registered, so it trails the transfers
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
  endtask

  initial begin
    int items_sent;
    int kind, reach, x0, y0, dxv, dyv, xe, ye, len, steps;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle step, single point, reversed axis lines, extreme spans
    send_item(lps_pkg::OP_STEP, '1);
    run_line(-32768, 32767, -32768, 32767, 0);
    run_line(32767, -32768, 32764, -32768, 3);
    run_line(-32768, 32767, -32768, 32765, 3);
    run_line(-32768, -32768, 32767, 32767, 3);
    run_line(32767, 32767, 32765, 32764, 5);
    run_line(0, 0, 2, 2, 4);

    // hold off until the pipeline has emptied
    in_tvalid <= 1'b0;
    drain_pixels();

    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        tx_idle_pct = 22;
        rx_idle_pct = 68;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        tx_idle_pct = 68;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      x0 = $signed(16'($urandom));
      y0 = $signed(16'($urandom));
      if ($urandom_range(0, 9) == 0)
        x0 = $urandom_range(0, 1) ? 32767 : -32768;
      if ($urandom_range(0, 9) == 0)
        y0 = $urandom_range(0, 1) ? 32767 : -32768;
      reach = ($urandom_range(0, 9) == 0) ? 300 : 12;
      dxv   = int'($urandom_range(0, 2 * reach)) - reach;
      dyv   = int'($urandom_range(0, 2 * reach)) - reach;
      kind  = $urandom_range(0, 99);
      if (kind < 15) begin
        dxv = 0;
        dyv = 0;
      end else if (kind < 30) begin
        dyv = 0;
      end else if (kind < 45) begin
        dxv = 0;
      end
      // keep the far end inside the coordinate range
      xe = x0 + dxv;
      if (xe > 32767 || xe < -32768)
        xe = x0 - dxv;
      ye = y0 + dyv;
      if (ye > 32767 || ye < -32768)
        ye = y0 - dyv;
      len = ((xe > x0) ? xe - x0 : x0 - xe) + ((ye > y0) ? ye - y0 : y0 - ye);

      kind = $urandom_range(0, 99);
      if (kind < 70)
        steps = len;
      else if (kind < 85)
        steps = len + $urandom_range(1, 3);
      else
        steps = $urandom_range(0, (len > 0) ? len - 1 : 0);
      if (steps > 40)
        steps = $urandom_range(10, 40);

      run_line(x0, y0, xe, ye, steps);
      items_sent += 1 + steps;
    end

    in_tvalid <= 1'b0;
    drain_pixels();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
